FILE: src/knt_pkg.sv
// package: payload types, token and status codes, lexer modes, keyword and single-character tables
`default_nettype none
package knt_pkg;
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [2:0]  status;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] pos_line;
    logic [15:0] pos_column;
    logic        ends_text;
    logic        run_last;
  } out_req_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_ZERO, M_NUMFIRST, M_DIGITS, M_EQ, M_BANG, M_DOT1, M_DOT2
  } mode_t;

  typedef enum logic [1:0] {B_DEC, B_BIN, B_OCT, B_HEX} base_t;

  localparam logic [5:0] T_IDENT  = 6'd0;
  localparam logic [5:0] T_NUMBER = 6'd1;
  localparam logic [5:0] T_KW0    = 6'd2;
  localparam logic [5:0] T_EQ     = 6'd19;
  localparam logic [5:0] T_EQEQ   = 6'd20;
  localparam logic [5:0] T_NE     = 6'd21;
  localparam logic [5:0] T_DOTS   = 6'd22;
  localparam logic [5:0] T_SINGLE = 6'd23;
  localparam logic [5:0] T_END    = 6'd34;

  localparam logic [2:0] S_OK        = 3'd0;
  localparam logic [2:0] S_UNEXPECT  = 3'd1;
  localparam logic [2:0] S_EXP_DIGIT = 3'd2;
  localparam logic [2:0] S_INV_DIGIT = 3'd3;
  localparam logic [2:0] S_BAD_NUM   = 3'd4;
  localparam logic [2:0] S_BANG      = 3'd5;
  localparam logic [2:0] S_DOTS      = 3'd6;

  localparam int KW_COUNT = 17;
  localparam int KW_MAX = 8;
  typedef logic [KW_MAX*8-1:0] kw_text_t;
  // keyword text, first char in the low byte
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    64'h63657073, 64'h7475706e69, 64'h6574617473, 64'h74757074756f,
    64'h6c6562616c, 64'h726f697661686562, 64'h7478656e, 64'h6c6c61726f66,
    64'h6e69, 64'h6669, 64'h6e656874, 64'h65736c65, 64'h686374697773,
    64'h65736163, 64'h746c7561666564, 64'h53, 64'h42
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd5, 4'd6, 4'd5, 4'd8, 4'd4, 4'd6, 4'd2, 4'd2, 4'd4, 4'd4,
    4'd6, 4'd4, 4'd7, 4'd1, 4'd1
  };
  localparam logic [7:0] SINGLE_CH [11] = '{
    8'h2d, 8'h7c, 8'h7e, 8'h3f, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h28, 8'h29, 8'h3a
  };
endpackage
`default_nettype wire

FILE: src/knt_kw_match.sv
// keyword lookup over the word buffer
`default_nettype none
module knt_kw_match #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LW = 5
) (
  input  wire logic [KEYWORD_CHARS*8-1:0] word,
  input  wire logic [LW-1:0]              word_len,
  output logic [5:0]                      token_type
);
  always_comb begin
    logic hit;
    token_type = knt_pkg::T_IDENT;
    for (int k = knt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      hit = (word_len == LW'(knt_pkg::KW_LEN[k]));
      // only the bytes inside the keyword length take part
      for (int i = 0; i < knt_pkg::KW_MAX; i++) begin
        if (i < int'(knt_pkg::KW_LEN[k]) && word[8*i +: 8] != knt_pkg::KW_TEXT[k][8*i +: 8])
          hit = 1'b0;
      end
      if (hit) token_type = knt_pkg::T_KW0 + 6'(k);
    end
  end
endmodule
`default_nettype wire

FILE: src/knt_out_q.sv
// four-entry result queue with stall toward the lexer
`default_nettype none
module knt_out_q (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push_n,
  input  wire knt_pkg::out_req_t push0,
  input  wire knt_pkg::out_req_t push1,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output knt_pkg::out_req_t      out_data
);
  localparam int DEPTH = 4;
  knt_pkg::out_req_t mem_r [DEPTH];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = (cnt_r != 3'd0) && !out_stall;
  assign out_valid = cnt_r != 3'd0;
  assign out_data = mem_r[rd_r];
  assign room = cnt_r <= 3'd2;
  assign cnt_nxt = cnt_r + 3'(push_n) - 3'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= push0;
    if (push_n == 2'd2) mem_r[wr_r + 2'd1] <= push1;
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_r + 2'(pop);
      wr_r <= wr_r + push_n;
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !room |-> push_n == 2'd0)
    else $error("push without room");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result moved");
endmodule
`default_nettype wire

FILE: src/keyword_number_tokenizer.sv
// top level: registered single-pass lexer feeding a result queue
`default_nettype none
// channel  dir  payload             handshake
// in_      in   ch, end_of_text     in_valid / in_stall
// out_     out  token result        out_valid / out_stall
// one request accepted per cycle while in_stall is low; each yields zero, one or two results
// lexer state and positions update in the accept cycle; results are written into
//   a four-entry queue and are driven from its head on out_data
// in_stall rises only when the queue could not absorb two more results
// rst_n is synchronous; no clearing pass, the word buffer is written before read
module keyword_number_tokenizer #(
  parameter int POS_BITS = 16,
  parameter int KEYWORD_CHARS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire knt_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output knt_pkg::out_req_t      out_data
);
  localparam int LW = $clog2(KEYWORD_CHARS + 2);
  localparam logic [POS_BITS-1:0] PMAX = '1;

  knt_pkg::mode_t mode_r, mode_nxt;
  knt_pkg::base_t base_r, base_nxt;
  logic [POS_BITS-1:0] coff_r, cline_r, ccol_r, toff_r, tline_r, tcol_r, tlen_r;
  logic [POS_BITS-1:0] coff_nxt, cline_nxt, ccol_nxt, toff_nxt, tline_nxt, tcol_nxt;
  logic [POS_BITS-1:0] tlen_nxt;
  logic [7:0] wbuf_r [KEYWORD_CHARS];
  logic [LW-1:0] wlen_r, wlen_nxt;
  logic failed_r, failed_nxt;
  logic [KEYWORD_CHARS*8-1:0] word;
  logic [5:0] kw_type;
  logic room, take;
  logic [1:0] n;
  knt_pkg::out_req_t r0, r1;
  logic wr_en;
  logic [LW-1:0] wr_idx;

  assign in_stall = !room;
  assign take = in_valid && room;

  always_comb begin
    for (int i = 0; i < KEYWORD_CHARS; i++) word[8*i +: 8] = wbuf_r[i];
  end

  knt_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS), .LW(LW)) u_kw (
    .word(word), .word_len(wlen_r), .token_type(kw_type)
  );

  function automatic logic [POS_BITS-1:0] sat(input logic [POS_BITS-1:0] v);
    return (v == PMAX) ? v : v + 1'b1;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic ws, alpha, dig, tail, vd, again, done;
    knt_pkg::out_req_t rr;
    c = in_data.ch;
    mode_nxt = mode_r; base_nxt = base_r;
    coff_nxt = coff_r; cline_nxt = cline_r; ccol_nxt = ccol_r;
    toff_nxt = toff_r; tline_nxt = tline_r; tcol_nxt = tcol_r; tlen_nxt = tlen_r;
    wlen_nxt = wlen_r; failed_nxt = failed_r;
    wr_en = 1'b0; wr_idx = wlen_r;
    n = 2'd0; r0 = '0; r1 = '0; rr = '0;
    again = 1'b0; done = 1'b0;
    ws = c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    dig = c >= "0" && c <= "9";
    tail = alpha || dig || c == "_";
    case (base_r)
      knt_pkg::B_BIN: vd = c == "0" || c == "1";
      knt_pkg::B_OCT: vd = c >= "0" && c <= "7";
      knt_pkg::B_HEX: vd = dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      default:        vd = dig;
    endcase
    // token result from the saved start
    rr.status = knt_pkg::S_OK;
    rr.start_offset = 16'(toff_r); rr.token_length = 16'(tlen_r);
    rr.pos_line = 16'(tline_r); rr.pos_column = 16'(tcol_r);
    if (in_data.end_of_text) begin
      if (!failed_r) begin
        done = 1'b1;
        unique case (mode_r)
          knt_pkg::M_IDENT: begin rr.token_type = kw_type; r0 = rr; n = 2'd1; end
          knt_pkg::M_ZERO, knt_pkg::M_DIGITS: begin
            rr.token_type = knt_pkg::T_NUMBER; r0 = rr; n = 2'd1;
          end
          knt_pkg::M_EQ: begin rr.token_type = knt_pkg::T_EQ; r0 = rr; n = 2'd1; end
          knt_pkg::M_NUMFIRST: begin
            r0 = '0; r0.status = knt_pkg::S_EXP_DIGIT; r0.start_offset = 16'(coff_r);
            r0.pos_line = 16'(cline_r); r0.pos_column = 16'(ccol_r);
            r0.ends_text = 1'b1; n = 2'd1; done = 1'b0;
          end
          knt_pkg::M_BANG, knt_pkg::M_DOT1, knt_pkg::M_DOT2: begin
            r0 = '0;
            r0.status = (mode_r == knt_pkg::M_BANG) ? knt_pkg::S_BANG : knt_pkg::S_DOTS;
            r0.start_offset = 16'(toff_r); r0.pos_line = 16'(tline_r);
            r0.pos_column = 16'(tcol_r); r0.ends_text = 1'b1; n = 2'd1; done = 1'b0;
          end
          default: ;
        endcase
        if (done) begin
          rr = '0; rr.token_type = knt_pkg::T_END; rr.start_offset = 16'(coff_r);
          rr.pos_line = 16'(cline_r); rr.pos_column = 16'(ccol_r); rr.ends_text = 1'b1;
          if (n == 2'd0) r0 = rr; else r1 = rr;
          n = n + 2'd1;
        end
      end
      mode_nxt = knt_pkg::M_IDLE; base_nxt = knt_pkg::B_DEC;
      coff_nxt = '0; cline_nxt = POS_BITS'(1); ccol_nxt = POS_BITS'(1);
      toff_nxt = '0; tline_nxt = POS_BITS'(1); tcol_nxt = POS_BITS'(1);
      tlen_nxt = '0; wlen_nxt = '0; failed_nxt = 1'b0;
    end else if (!failed_r) begin
      // first pass: the active token
      unique case (mode_r)
        knt_pkg::M_IDLE: again = 1'b1;
        knt_pkg::M_IDENT:
          if (tail) begin
            wr_en = wlen_r < LW'(KEYWORD_CHARS); wr_idx = wlen_r;
            if (wlen_r <= LW'(KEYWORD_CHARS)) wlen_nxt = wlen_r + 1'b1;
            done = 1'b1;
          end else begin
            rr.token_type = kw_type; r0 = rr; n = 2'd1; again = 1'b1;
          end
        knt_pkg::M_ZERO, knt_pkg::M_DIGITS:
          if (mode_r == knt_pkg::M_ZERO && (c == "b" || c == "o" || c == "x" || c == "X"))
          begin
            base_nxt = (c == "b") ? knt_pkg::B_BIN :
                       (c == "o") ? knt_pkg::B_OCT : knt_pkg::B_HEX;
            mode_nxt = knt_pkg::M_NUMFIRST; done = 1'b1;
          end else if (vd) begin
            mode_nxt = knt_pkg::M_DIGITS; done = 1'b1;
          end else if (tail) begin
            r0 = '0; r0.status = knt_pkg::S_BAD_NUM; n = 2'd1;
          end else begin
            rr.token_type = knt_pkg::T_NUMBER; r0 = rr; n = 2'd1; again = 1'b1;
          end
        knt_pkg::M_NUMFIRST:
          if (ws) begin r0 = '0; r0.status = knt_pkg::S_EXP_DIGIT; n = 2'd1; end
          else if (!vd) begin r0 = '0; r0.status = knt_pkg::S_INV_DIGIT; n = 2'd1; end
          else begin mode_nxt = knt_pkg::M_DIGITS; done = 1'b1; end
        knt_pkg::M_EQ:
          if (c == "=") begin
            tlen_nxt = sat(tlen_r); rr.token_length = 16'(tlen_nxt);
            rr.token_type = knt_pkg::T_EQEQ; r0 = rr; n = 2'd1;
            mode_nxt = knt_pkg::M_IDLE; done = 1'b1;
          end else begin
            rr.token_type = knt_pkg::T_EQ; r0 = rr; n = 2'd1; again = 1'b1;
          end
        knt_pkg::M_BANG, knt_pkg::M_DOT1, knt_pkg::M_DOT2:
          if ((mode_r == knt_pkg::M_BANG && c == "=") || (mode_r != knt_pkg::M_BANG && c == "."))
          begin
            done = 1'b1;
            if (mode_r == knt_pkg::M_DOT1) mode_nxt = knt_pkg::M_DOT2;
            else begin
              tlen_nxt = sat(tlen_r); rr.token_length = 16'(tlen_nxt);
              rr.token_type = (mode_r == knt_pkg::M_BANG) ? knt_pkg::T_NE : knt_pkg::T_DOTS;
              r0 = rr; n = 2'd1; mode_nxt = knt_pkg::M_IDLE;
            end
          end else begin
            r0 = '0; n = 2'd1; r0.ends_text = 1'b1;
            r0.status = (mode_r == knt_pkg::M_BANG) ? knt_pkg::S_BANG : knt_pkg::S_DOTS;
            r0.start_offset = 16'(toff_r); r0.pos_line = 16'(tline_r);
            r0.pos_column = 16'(tcol_r); failed_nxt = 1'b1; mode_nxt = knt_pkg::M_IDLE;
          end
        default: again = 1'b1;
      endcase
      // errors at the current byte from the first pass
      if (!done && !again && r0.status != knt_pkg::S_OK && !failed_nxt) begin
        r0.start_offset = 16'(coff_r); r0.pos_line = 16'(cline_r);
        r0.pos_column = 16'(ccol_r); r0.ends_text = 1'b1;
        failed_nxt = 1'b1; mode_nxt = knt_pkg::M_IDLE;
      end
      if (again) begin
        // second pass: byte lexed from idle
        mode_nxt = knt_pkg::M_IDLE;
        if (ws) done = 1'b1;
        else begin
          toff_nxt = coff_r; tline_nxt = cline_r; tcol_nxt = ccol_r; tlen_nxt = '0;
          done = 1'b1;
          if (alpha || c == "_") begin
            wr_en = 1'b1; wr_idx = '0; wlen_nxt = LW'(1); mode_nxt = knt_pkg::M_IDENT;
          end else if (dig) begin
            base_nxt = knt_pkg::B_DEC;
            mode_nxt = (c == "0") ? knt_pkg::M_ZERO : knt_pkg::M_DIGITS;
          end else if (c == "=") mode_nxt = knt_pkg::M_EQ;
          else if (c == "!") mode_nxt = knt_pkg::M_BANG;
          else if (c == ".") mode_nxt = knt_pkg::M_DOT1;
          else begin
            rr = '0; rr.status = knt_pkg::S_UNEXPECT; rr.start_offset = 16'(coff_r);
            rr.pos_line = 16'(cline_r); rr.pos_column = 16'(ccol_r); rr.ends_text = 1'b1;
            for (int k = 0; k < 11; k++) begin
              if (c == knt_pkg::SINGLE_CH[k]) begin
                rr.token_type = knt_pkg::T_SINGLE + 6'(k); rr.status = knt_pkg::S_OK;
                rr.token_length = 16'(1); rr.ends_text = 1'b0;
                rr.start_offset = 16'(coff_r);
              end
            end
            if (rr.status != knt_pkg::S_OK) begin
              done = 1'b0; failed_nxt = 1'b1;
            end
            if (n == 2'd0) r0 = rr; else r1 = rr;
            n = n + 2'd1;
          end
        end
      end
      if (done) begin
        // consume the byte
        coff_nxt = sat(coff_r);
        if (!ws || !again) tlen_nxt = (again && !ws) ? POS_BITS'(1) :
            ((mode_r == knt_pkg::M_EQ || mode_r == knt_pkg::M_BANG ||
              mode_r == knt_pkg::M_DOT2) ? tlen_nxt : sat(tlen_r));
        else tlen_nxt = sat(tlen_r);
        if (c == 8'h0a) begin cline_nxt = sat(cline_r); ccol_nxt = POS_BITS'(1); end
        else ccol_nxt = sat(ccol_r);
      end
    end
    if (n == 2'd1) r0.run_last = 1'b1;
    if (n == 2'd2) r1.run_last = 1'b1;
  end

  knt_out_q u_q (
    .clk(clk), .rst_n(rst_n), .push_n(take ? n : 2'd0), .push0(r0), .push1(r1),
    .room(room), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always_ff @(posedge clk) begin
    if (take && wr_en) wbuf_r[wr_idx[$clog2(KEYWORD_CHARS)-1:0]] <= in_data.ch;
    if (!rst_n) begin
      mode_r <= knt_pkg::M_IDLE; base_r <= knt_pkg::B_DEC;
      coff_r <= '0; cline_r <= POS_BITS'(1); ccol_r <= POS_BITS'(1);
      toff_r <= '0; tline_r <= POS_BITS'(1); tcol_r <= POS_BITS'(1);
      tlen_r <= '0; wlen_r <= '0; failed_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt; base_r <= base_nxt;
      coff_r <= coff_nxt; cline_r <= cline_nxt; ccol_r <= ccol_nxt;
      toff_r <= toff_nxt; tline_r <= tline_nxt; tcol_r <= tcol_nxt;
      tlen_r <= tlen_nxt; wlen_r <= wlen_nxt; failed_r <= failed_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) failed_r |-> mode_r == knt_pkg::M_IDLE)
    else $error("failed text left a token open");
  assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.end_of_text |=> !failed_r && coff_r == '0)
    else $error("end request did not clear text state");
  assert property (@(posedge clk) disable iff (!rst_n) cline_r != '0 && ccol_r != '0)
    else $error("position went to zero");
endmodule
`default_nettype wire

FILE: verif/keyword_number_tokenizer_tb.sv
// testbench: keyword_number_tokenizer against a built-in lexer predictor, random stalls
`default_nettype none
module keyword_number_tokenizer_tb;

  localparam int N_ITEMS   = 1050;
  localparam int CYC_LIMIT = 400000;
  localparam int N_DIR     = 22;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  knt_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall;
  knt_pkg::out_req_t out_data;

  keyword_number_tokenizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // directed row: byte or end item, plus an optional typed-in first result
  typedef struct {
    logic [7:0] ch;
    bit         eot;
    bit         lit;
    logic [5:0] ty;
    logic [2:0] st;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    // "S==:" then end: keyword S, ==, colon, end token
    '{8'h53, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h3d, 0, 1, knt_pkg::T_KW0 + 6'd15, knt_pkg::S_OK},
    '{8'h3d, 0, 1, knt_pkg::T_EQEQ, knt_pkg::S_OK},
    '{8'h3a, 0, 1, knt_pkg::T_SINGLE + 6'd10, knt_pkg::S_OK},
    '{8'h00, 1, 1, knt_pkg::T_END, knt_pkg::S_OK},
    // bang without equals, then end after an error gives nothing
    '{8'h21, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h78, 0, 1, knt_pkg::T_IDENT, knt_pkg::S_BANG},
    '{8'ha5, 1, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    // high byte is not a letter
    '{8'hff, 0, 1, knt_pkg::T_IDENT, knt_pkg::S_UNEXPECT},
    '{8'h5a, 1, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    // 0b2: invalid digit right after the prefix
    '{8'h30, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h62, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h32, 0, 1, knt_pkg::T_IDENT, knt_pkg::S_INV_DIGIT},
    '{8'hff, 1, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    // lone dot closed by end
    '{8'h2e, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h00, 1, 1, knt_pkg::T_IDENT, knt_pkg::S_DOTS},
    // 0x closed by end: digit expected
    '{8'h30, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h78, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h81, 1, 1, knt_pkg::T_IDENT, knt_pkg::S_EXP_DIGIT},
    // letter glued to a decimal number
    '{8'h39, 0, 0, knt_pkg::T_IDENT, knt_pkg::S_OK},
    '{8'h61, 0, 1, knt_pkg::T_IDENT, knt_pkg::S_BAD_NUM},
    '{8'h7e, 1, 0, knt_pkg::T_IDENT, knt_pkg::S_OK}
  };

  // ---------------- lexer predictor ----------------
  knt_pkg::mode_t lx_mode;
  knt_pkg::base_t lx_base;
  logic [15:0] cur_off, cur_line, cur_col;
  logic [15:0] tok_off, tok_line, tok_col, tok_len;
  logic [7:0]  word_buf [knt_pkg::KW_MAX];
  int          word_len;
  bit          lx_failed;

  knt_pkg::out_req_t token_q [$];   // results still owed by the block
  knt_pkg::out_req_t step_res [$];  // results of the latest request
  int          fails, n_req, n_tok, n_err, n_texts;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_tail(logic [7:0] c);
    return is_alpha(c) || is_dig(c) || c == "_";
  endfunction

  function automatic bit digit_ok(logic [7:0] c);
    case (lx_base)
      knt_pkg::B_BIN: return c == "0" || c == "1";
      knt_pkg::B_OCT: return c >= "0" && c <= "7";
      knt_pkg::B_HEX: return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      default: return is_dig(c);
    endcase
  endfunction

  function automatic void push_res(logic [5:0] ty, logic [2:0] st, logic [15:0] off,
                                   logic [15:0] len, logic [15:0] ln, logic [15:0] col,
                                   bit ends);
    knt_pkg::out_req_t r;
    if (step_res.size() >= 2) return;
    r = '0;
    r.token_type = ty;
    r.status = st;
    r.start_offset = off;
    r.token_length = len;
    r.pos_line = ln;
    r.pos_column = col;
    r.ends_text = ends;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void emit_tok(logic [5:0] ty);
    push_res(ty, knt_pkg::S_OK, tok_off, tok_len, tok_line, tok_col, 0);
    lx_mode = knt_pkg::M_IDLE;
  endfunction

  function automatic void emit_word();
    knt_pkg::kw_text_t w;
    logic [5:0] ty;
    w = '0;
    ty = knt_pkg::T_IDENT;
    if (word_len <= knt_pkg::KW_MAX) begin
      for (int i = 0; i < word_len; i++) w[i*8 +: 8] = word_buf[i];
      for (int k = knt_pkg::KW_COUNT - 1; k >= 0; k--)
        if (int'(knt_pkg::KW_LEN[k]) == word_len && knt_pkg::KW_TEXT[k] == w)
          ty = knt_pkg::T_KW0 + 6'(k);
    end
    emit_tok(ty);
  endfunction

  function automatic void fail_at(logic [2:0] st, logic [15:0] off, logic [15:0] ln,
                                  logic [15:0] col);
    push_res(knt_pkg::T_IDENT, st, off, 16'd0, ln, col, 1);
    lx_failed = 1;
    lx_mode = knt_pkg::M_IDLE;
  endfunction

  function automatic void advance(logic [7:0] c);
    cur_off = sat_inc(cur_off);
    tok_len = sat_inc(tok_len);
    if (c == 8'h0a) begin
      cur_line = sat_inc(cur_line);
      cur_col = 16'd1;
    end else begin
      cur_col = sat_inc(cur_col);
    end
  endfunction

  function automatic void clear_text();
    lx_mode = knt_pkg::M_IDLE;
    lx_base = knt_pkg::B_DEC;
    cur_off = 0; cur_line = 1; cur_col = 1;
    tok_off = 0; tok_line = 1; tok_col = 1; tok_len = 0;
    for (int i = 0; i < knt_pkg::KW_MAX; i++) word_buf[i] = 8'h00;
    word_len = 0;
    lx_failed = 0;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    if (is_ws(c)) begin
      advance(c);
      return;
    end
    tok_off = cur_off; tok_line = cur_line; tok_col = cur_col; tok_len = 0;
    if (is_alpha(c) || c == "_") begin
      word_buf[0] = c;
      word_len = 1;
      lx_mode = knt_pkg::M_IDENT;
    end else if (is_dig(c)) begin
      lx_base = knt_pkg::B_DEC;
      lx_mode = (c == "0") ? knt_pkg::M_ZERO : knt_pkg::M_DIGITS;
    end else if (c == "=") begin
      lx_mode = knt_pkg::M_EQ;
    end else if (c == "!") begin
      lx_mode = knt_pkg::M_BANG;
    end else if (c == ".") begin
      lx_mode = knt_pkg::M_DOT1;
    end else begin
      for (int k = 0; k < 11; k++)
        if (knt_pkg::SINGLE_CH[k] == c) begin
          advance(c);
          emit_tok(knt_pkg::T_SINGLE + 6'(k));
          return;
        end
      fail_at(knt_pkg::S_UNEXPECT, cur_off, cur_line, cur_col);
      return;
    end
    advance(c);
  endfunction

  // returns 1 when the byte closes the number and must be lexed again
  function automatic bit lex_digits(logic [7:0] c);
    if (digit_ok(c)) begin
      advance(c);
      return 0;
    end
    if (is_tail(c)) begin
      fail_at(knt_pkg::S_BAD_NUM, cur_off, cur_line, cur_col);
      return 0;
    end
    emit_tok(knt_pkg::T_NUMBER);
    return 1;
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    bit again;
    again = 0;
    case (lx_mode)
      knt_pkg::M_IDENT: begin
        if (is_tail(c)) begin
          if (word_len < knt_pkg::KW_MAX) word_buf[word_len] = c;
          if (word_len <= knt_pkg::KW_MAX) word_len++;
          advance(c);
        end else begin
          emit_word();
          again = 1;
        end
      end
      knt_pkg::M_ZERO: begin
        if (c == "b" || c == "o" || c == "x" || c == "X") begin
          lx_base = (c == "b") ? knt_pkg::B_BIN : (c == "o") ? knt_pkg::B_OCT : knt_pkg::B_HEX;
          advance(c);
          lx_mode = knt_pkg::M_NUMFIRST;
        end else begin
          lx_mode = knt_pkg::M_DIGITS;
          again = lex_digits(c);
        end
      end
      knt_pkg::M_NUMFIRST: begin
        if (is_ws(c)) fail_at(knt_pkg::S_EXP_DIGIT, cur_off, cur_line, cur_col);
        else if (!digit_ok(c)) fail_at(knt_pkg::S_INV_DIGIT, cur_off, cur_line, cur_col);
        else begin
          advance(c);
          lx_mode = knt_pkg::M_DIGITS;
        end
      end
      knt_pkg::M_DIGITS: again = lex_digits(c);
      knt_pkg::M_EQ: begin
        if (c == "=") begin
          advance(c);
          emit_tok(knt_pkg::T_EQEQ);
        end else begin
          emit_tok(knt_pkg::T_EQ);
          again = 1;
        end
      end
      knt_pkg::M_BANG: begin
        if (c == "=") begin
          advance(c);
          emit_tok(knt_pkg::T_NE);
        end else fail_at(knt_pkg::S_BANG, tok_off, tok_line, tok_col);
      end
      knt_pkg::M_DOT1, knt_pkg::M_DOT2: begin
        if (c != ".") fail_at(knt_pkg::S_DOTS, tok_off, tok_line, tok_col);
        else begin
          advance(c);
          if (lx_mode == knt_pkg::M_DOT2) emit_tok(knt_pkg::T_DOTS);
          else lx_mode = knt_pkg::M_DOT2;
        end
      end
      default: again = 1;
    endcase
    if (again) lex_idle(c);
  endfunction

  function automatic void lex_end();
    case (lx_mode)
      knt_pkg::M_IDENT: emit_word();
      knt_pkg::M_ZERO, knt_pkg::M_DIGITS: emit_tok(knt_pkg::T_NUMBER);
      knt_pkg::M_NUMFIRST: begin
        fail_at(knt_pkg::S_EXP_DIGIT, cur_off, cur_line, cur_col);
        return;
      end
      knt_pkg::M_EQ: emit_tok(knt_pkg::T_EQ);
      knt_pkg::M_BANG: begin
        fail_at(knt_pkg::S_BANG, tok_off, tok_line, tok_col);
        return;
      end
      knt_pkg::M_DOT1, knt_pkg::M_DOT2: begin
        fail_at(knt_pkg::S_DOTS, tok_off, tok_line, tok_col);
        return;
      end
      default: ;
    endcase
    push_res(knt_pkg::T_END, knt_pkg::S_OK, cur_off, 16'd0, cur_line, cur_col, 1);
  endfunction

  // works out the results of one accepted request and queues them
  function automatic void predict_request(knt_pkg::in_req_t rq);
    step_res.delete();
    if (rq.end_of_text) begin
      if (!lx_failed) lex_end();
      clear_text();
      n_texts++;
    end else if (!lx_failed) begin
      lex_byte(rq.ch);
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
    foreach (step_res[i]) token_q.insert(token_q.size(), step_res[i]);
  endfunction

  // ---------------- clock, reset, timeout ----------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYC_LIMIT) @(posedge clk);
    $display("[keyword_number_tokenizer] ERROR");
    $finish;
  end

  // ---------------- monitors, sampled at the rising edge ----------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_request(in_data);
      n_req++;
    end
  end

  always @(posedge clk) begin
    knt_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("result with nothing expected: type %0d status %0d",
               out_data.token_type, out_data.status);
        fails++;
      end else begin
        want = token_q.pop_front();
        if (want.status != knt_pkg::S_OK) n_err++;
        else n_tok++;
        if (out_data.token_type != want.token_type) begin
          $error("token_type exp %0d got %0d", want.token_type, out_data.token_type);
          fails++;
        end
        if (out_data.status != want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status);
          fails++;
        end
        if (out_data.start_offset != want.start_offset) begin
          $error("start_offset exp %0d got %0d", want.start_offset, out_data.start_offset);
          fails++;
        end
        if (out_data.token_length != want.token_length) begin
          $error("token_length exp %0d got %0d", want.token_length, out_data.token_length);
          fails++;
        end
        if (out_data.pos_line != want.pos_line) begin
          $error("pos_line exp %0d got %0d", want.pos_line, out_data.pos_line);
          fails++;
        end
        if (out_data.pos_column != want.pos_column) begin
          $error("pos_column exp %0d got %0d", want.pos_column, out_data.pos_column);
          fails++;
        end
        if (out_data.ends_text != want.ends_text) begin
          $error("ends_text exp %0d got %0d", want.ends_text, out_data.ends_text);
          fails++;
        end
        if (out_data.run_last != want.run_last) begin
          $error("run_last exp %0d got %0d", want.run_last, out_data.run_last);
          fails++;
        end
      end
    end
  end

  // ---------------- receiver stalls ----------------
  bit calm;        // last part of the run: no idling on either side
  bit long_hold;   // asks for one long receiver hold-off
  int hold_left, burst_left;

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(1, 9);
      end
    end
  end

  // ---------------- sender ----------------
  // called at a falling edge; returns at a falling edge after acceptance, sometimes after a random idle gap
  task automatic send_req(logic [7:0] c, bit eot);
    knt_pkg::in_req_t rq;
    rq.ch = c;
    rq.end_of_text = eot;
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  logic [7:0] txt [$];   // bytes of the random text being built

  function automatic void add_ch(logic [7:0] c);
    txt.insert(txt.size(), c);
  endfunction

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void add_separator();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_ch(" ");
      4: add_ch(8'h0a);
      5: add_ch(8'h09);
      6: add_ch(8'(13 - $urandom_range(0, 2)));
      default: ;   // tokens touch
    endcase
  endfunction

  // appends one mostly well-formed token with random content
  function automatic void add_token();
    int k, n;
    case ($urandom_range(0, 11))
      0, 1: begin
        k = $urandom_range(0, knt_pkg::KW_COUNT - 1);
        for (int i = 0; i < knt_pkg::KW_LEN[k]; i++) add_ch(knt_pkg::KW_TEXT[k][i*8 +: 8]);
      end
      2, 3: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        add_ch(pick_char("abcdefghijklmnopqrstuvwxyzSBQ_"));
        for (int i = 1; i < n; i++)
          add_ch(pick_char("abcdefghinoprstuvwxyzAZ_0789"));
      end
      4: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) add_ch(pick_char("0123456789"));
      end
      5: begin
        add_ch("0");
        case ($urandom_range(0, 3))
          0: begin
            add_ch("b");
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_ch(pick_char("01"));
          end
          1: begin
            add_ch("o");
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_ch(pick_char("01234567"));
          end
          default: begin
            add_ch($urandom_range(0, 1) ? "x" : "X");
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_ch(pick_char("0123456789abcdefABCDEF"));
          end
        endcase
      end
      6: begin
        case ($urandom_range(0, 2))
          0: add_ch("=");
          1: begin add_ch("="); add_ch("="); end
          default: begin add_ch("!"); add_ch("="); end
        endcase
      end
      7: begin add_ch("."); add_ch("."); add_ch("."); end
      8, 9: add_ch(knt_pkg::SINGLE_CH[$urandom_range(0, 10)]);
      10: add_ch(8'($urandom_range(0, 255)));   // noise
      default: begin
        // broken sequences
        case ($urandom_range(0, 5))
          0: add_ch("!");
          1: begin add_ch("."); add_ch("."); end
          2: begin add_ch("0"); add_ch("x"); end
          3: begin add_ch("0"); add_ch("b"); add_ch("9"); end
          4: begin add_ch("7"); add_ch("_"); end
          default: begin add_ch("0"); add_ch("o"); add_ch("8"); end
        endcase
      end
    endcase
  endfunction

  bit   long_done, pause_done;
  int   sent;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    fails = 0; n_req = 0; n_tok = 0; n_err = 0; n_texts = 0;
    calm = 0; long_hold = 0;
    clear_text();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: rows with a typed-in result check the first prediction
    for (int i = 0; i < N_DIR; i++) begin
      send_req(dir_rows[i].ch, dir_rows[i].eot);
      if (dir_rows[i].lit) begin
        if (step_res.size() == 0 || step_res[0].token_type != dir_rows[i].ty ||
            step_res[0].status != dir_rows[i].st) begin
          $error("directed row %0d: first result type/status exp %0d/%0d", i,
                 dir_rows[i].ty, dir_rows[i].st);
          fails++;
        end
      end
    end
    sent = N_DIR;

    // random texts, each closed by an end request
    while (sent < N_ITEMS) begin
      txt.delete();
      repeat ($urandom_range(1, 12)) begin
        add_token();
        add_separator();
      end
      foreach (txt[i]) begin
        if (sent >= N_ITEMS - 1) break;
        send_req(txt[i], 1'b0);
        sent++;
        if (!long_done && sent > 300) begin
          // receiver holds off while requests keep coming
          long_done = 1;
          long_hold = 1;
        end
        if (!pause_done && sent > 600) begin
          // sender waits until everything owed has drained
          pause_done = 1;
          in_valid <= 1'b0;
          do @(negedge clk); while (token_q.size() != 0);
        end
        if (sent > N_ITEMS * 85 / 100) calm = 1;
      end
      send_req(8'($urandom_range(0, 255)), 1'b1);
      sent++;
    end
    in_valid <= 1'b0;

    while (token_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("requests %0d in %0d texts; tokens %0d and error results %0d checked",
             n_req, n_texts, n_tok, n_err);
    if (fails == 0 && token_q.size() == 0) begin
      $display("[keyword_number_tokenizer] OK");
    end else begin
      $display("[keyword_number_tokenizer] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
